// File: rtl/hfi_pkg.sv
// ----------------------------------------------------------------------------
// hfi_pkg
// Shared types and constants of the host frame interceptor.
// ----------------------------------------------------------------------------
package hfi_pkg;

    localparam int CAPTURE_DEPTH_DEF = 8;
    localparam int CNT_W             = 4;
    localparam int MAX_RESULTS       = 3;
    localparam int LEFT_W            = 2;
    localparam int CFG_IDX_W         = 2;

    localparam logic [7:0] IMU_LEN_BYTE      = 8'h03;
    localparam logic [7:0] HDR_LEN           = 8'd2;
    localparam logic [7:0] IMU_CMD_RESET     = 8'h90;
    localparam logic [7:0] IMU_CHECK_RESET   = 8'h93;
    localparam logic [7:0] BRIDGE_OPC_RESET  = 8'h00;

    localparam logic [1:0] ROUTE_BOARD  = 2'd0;
    localparam logic [1:0] ROUTE_BRIDGE = 2'd1;
    localparam logic [1:0] ROUTE_IMU    = 2'd2;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_IMU  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMU_CMD       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_CHECK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_OPCODE = 2'd2;

    typedef struct packed {
        logic [1:0] route;
        logic [7:0] data_byte;
        logic       bridge_done;
    } result_t;

    typedef struct packed {
        logic [7:0] imu_cmd;
        logic [7:0] imu_check;
        logic [7:0] bridge_opcode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       held_count;
        logic [7:0]       held0;
        logic [7:0]       held1;
        logic [7:0]       body_left;
        logic             capturing;
        logic [CNT_W-1:0] capture_target;
        logic [CNT_W-1:0] capture_count;
    } frame_state_t;

endpackage

// File: rtl/hfi_stream_if.sv
// ----------------------------------------------------------------------------
// hfi_stream_if
// Valid/ready channels for host bytes and sorted result bytes.
// ----------------------------------------------------------------------------
interface hfi_host_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;

    modport source (output valid, output host_byte, input ready);
    modport sink   (input valid, input host_byte, output ready);
endinterface

interface hfi_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] route;
    logic [7:0] data_byte;
    logic       bridge_done;
    logic       last;

    modport source (output valid, output route, output data_byte, output bridge_done,
                    output last, input ready);
    modport sink   (input valid, input route, input data_byte, input bridge_done,
                    input last, output ready);
endinterface

// File: rtl/host_frame_interceptor_unit.sv
// ----------------------------------------------------------------------------
// host_frame_interceptor_unit
// Sorts length-prefixed host frames to the board, the bridge or an IMU event.
// ----------------------------------------------------------------------------
// A host byte is decoded in the cycle it is accepted and its zero to three
// result beats are loaded into a three-entry result buffer, which drains one
// beat per cycle while the receiver is ready. A byte that gives no result or
// one result lets the next byte follow back to back; after a released header
// or a mismatched IMU request the host waits on the single result port. The next
// byte is taken in the same cycle as the final beat of the previous one leaves.
module host_frame_interceptor_unit #(
    parameter int CAPTURE_DEPTH = hfi_pkg::CAPTURE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hfi_host_if.sink                      host,
    hfi_result_if.source                  result,
    input  logic                          wr_en,
    input  logic [hfi_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]                    wr_data
);

    hfi_pkg::cfg_t                                cfg_reg;
    hfi_pkg::frame_state_t                        state_reg;
    hfi_pkg::frame_state_t                        state_next;
    hfi_pkg::result_t [hfi_pkg::MAX_RESULTS-1:0]  res_reg;
    hfi_pkg::result_t [hfi_pkg::MAX_RESULTS-1:0]  res_next;
    logic [hfi_pkg::LEFT_W-1:0]                   left_reg;
    logic [hfi_pkg::LEFT_W-1:0]                   dec_count;
    logic                                         in_fire;
    logic                                         out_fire;

    hfi_decode #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_decode (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .host_byte (host.host_byte),
        .nxt       (state_next),
        .count     (dec_count),
        .res       (res_next)
    );

    assign out_fire = result.valid && result.ready;
    // free once the buffer is empty or its final beat leaves now
    assign host.ready = (left_reg == 2'd0) || (left_reg == 2'd1 && result.ready);
    assign in_fire    = host.valid && host.ready;

    assign result.valid       = left_reg != 2'd0;
    assign result.route       = res_reg[0].route;
    assign result.data_byte   = res_reg[0].data_byte;
    assign result.bridge_done = res_reg[0].bridge_done;
    assign result.last        = left_reg == 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imu_cmd       <= hfi_pkg::IMU_CMD_RESET;
            cfg_reg.imu_check     <= hfi_pkg::IMU_CHECK_RESET;
            cfg_reg.bridge_opcode <= hfi_pkg::BRIDGE_OPC_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                hfi_pkg::REG_IMU_CMD:       cfg_reg.imu_cmd       <= wr_data;
                hfi_pkg::REG_IMU_CHECK:     cfg_reg.imu_check     <= wr_data;
                hfi_pkg::REG_BRIDGE_OPCODE: cfg_reg.bridge_opcode <= wr_data;
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            left_reg  <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            left_reg  <= dec_count;
        end
        else if (out_fire)
        begin
            left_reg <= left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
        else if (out_fire)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    // buffer never holds more beats than one byte can cause
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 2'd3)
        else $error("result buffer overfilled");

    // an open capture has not reached its announced length
    a_capture_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.capturing |-> (state_reg.capture_count < state_reg.capture_target &&
                                 state_reg.body_left == 8'd0 &&
                                 state_reg.held_count == hfi_pkg::HELD_NONE))
        else $error("capture state inconsistent");

    // end-of-capture flag only on bridge beats
    a_done_route: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.bridge_done) |-> result.route == hfi_pkg::ROUTE_BRIDGE)
        else $error("bridge_done on non-bridge beat");

endmodule

// File: rtl/hfi_decode.sv
// ----------------------------------------------------------------------------
// hfi_decode
// Sorts one host byte against the frame state: results and next state.
// ----------------------------------------------------------------------------
module hfi_decode #(
    parameter int CAPTURE_DEPTH = hfi_pkg::CAPTURE_DEPTH_DEF
) (
    input  hfi_pkg::frame_state_t                 cur,
    input  hfi_pkg::cfg_t                         cfg,
    input  logic [7:0]                            host_byte,
    output hfi_pkg::frame_state_t                 nxt,
    output logic [hfi_pkg::LEFT_W-1:0]            count,
    output hfi_pkg::result_t [hfi_pkg::MAX_RESULTS-1:0] res
);

    localparam logic [7:0] DEPTH_BYTE = 8'(CAPTURE_DEPTH);

    logic [hfi_pkg::CNT_W-1:0] count_inc;

    function automatic hfi_pkg::result_t mk(input logic [1:0] route, input logic [7:0] data,
                                            input logic done);
        hfi_pkg::result_t r;
        r.route       = route;
        r.data_byte   = data;
        r.bridge_done = done;
        return r;
    endfunction

    assign count_inc = cur.capture_count + hfi_pkg::CNT_W'(1);

    always_comb
    begin
        nxt   = cur;
        count = '0;
        res   = '0;
        if (cur.capturing)
        begin
            nxt.capture_count = count_inc;
            nxt.capturing     = !(count_inc >= cur.capture_target);
            res[0] = mk(hfi_pkg::ROUTE_BRIDGE, host_byte, count_inc >= cur.capture_target);
            count  = 2'd1;
        end
        else if (cur.body_left != 8'd0)
        begin
            nxt.body_left = cur.body_left - 8'd1;
            res[0] = mk(hfi_pkg::ROUTE_BOARD, host_byte, 1'b0);
            count  = 2'd1;
        end
        else
        begin
            case (cur.held_count)
                hfi_pkg::HELD_IMU:
                begin
                    nxt.held_count = hfi_pkg::HELD_NONE;
                    if (host_byte == cfg.imu_check)
                    begin
                        res[0] = mk(hfi_pkg::ROUTE_IMU, 8'd0, 1'b0);
                        count  = 2'd1;
                    end
                    else
                    begin
                        res[0] = mk(hfi_pkg::ROUTE_BOARD, cur.held0, 1'b0);
                        res[1] = mk(hfi_pkg::ROUTE_BOARD, cur.held1, 1'b0);
                        res[2] = mk(hfi_pkg::ROUTE_BOARD, host_byte, 1'b0);
                        count  = 2'd3;
                    end
                end
                hfi_pkg::HELD_NONE:
                begin
                    if (host_byte < hfi_pkg::HDR_LEN)
                    begin
                        res[0] = mk(hfi_pkg::ROUTE_BOARD, host_byte, 1'b0);
                        count  = 2'd1;
                    end
                    else
                    begin
                        nxt.held0      = host_byte;
                        nxt.held_count = hfi_pkg::HELD_ONE;
                    end
                end
                hfi_pkg::HELD_ONE:
                begin
                    // second header byte decides the path of the frame
                    nxt.held1 = host_byte;
                    if (cur.held0 == hfi_pkg::IMU_LEN_BYTE && host_byte == cfg.imu_cmd)
                    begin
                        nxt.held_count = hfi_pkg::HELD_IMU;
                    end
                    else
                    begin
                        nxt.held_count = hfi_pkg::HELD_NONE;
                        if (host_byte == cfg.bridge_opcode && cur.held0 <= DEPTH_BYTE)
                        begin
                            if (cur.held0 > hfi_pkg::HDR_LEN)
                            begin
                                nxt.capture_target = cur.held0[hfi_pkg::CNT_W-1:0];
                                nxt.capture_count  = hfi_pkg::CNT_W'(hfi_pkg::HDR_LEN);
                                nxt.capturing      = 1'b1;
                                res[0] = mk(hfi_pkg::ROUTE_BRIDGE, cur.held0, 1'b0);
                                res[1] = mk(hfi_pkg::ROUTE_BRIDGE, host_byte, 1'b0);
                                count  = 2'd2;
                            end
                        end
                        else
                        begin
                            nxt.body_left = cur.held0 - hfi_pkg::HDR_LEN;
                            res[0] = mk(hfi_pkg::ROUTE_BOARD, cur.held0, 1'b0);
                            res[1] = mk(hfi_pkg::ROUTE_BOARD, host_byte, 1'b0);
                            count  = 2'd2;
                        end
                    end
                end
                default:
                begin
                    nxt.held_count = hfi_pkg::HELD_NONE;
                end
            endcase
        end
    end

endmodule

// File: sim/host_frame_interceptor_unit_tb.sv
// ----------------------------------------------------------------------------
// host_frame_interceptor_unit_tb
// Streams host frames into the interceptor and checks every sorted beat
// against an in-bench predictor. Covers ordinary relay, IMU requests with
// good and bad check bytes, and bridge capture up to and past the capture
// depth. Also covers register changes between phases, random idling on both
// channels, a long receiver stall and a full drain pause.
// ----------------------------------------------------------------------------
module host_frame_interceptor_unit_tb;

    localparam int CAPTURE_DEPTH = hfi_pkg::CAPTURE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_STALL    = 60;
    localparam int IDLE_LIMIT    = 4000;

    typedef struct packed {
        logic [1:0] route;
        logic [7:0] data_byte;
        logic       bridge_done;
        logic       last;
    } beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          wr_en;
    logic [hfi_pkg::CFG_IDX_W-1:0] wr_index;
    logic [7:0]                    wr_data;

    hfi_host_if   host_ch ();
    hfi_result_if result_ch ();

    host_frame_interceptor_unit #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .host     (host_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // predictor copy of registers and frame state
    hfi_pkg::cfg_t             cfg;
    logic [1:0]                held_cnt    = hfi_pkg::HELD_NONE;
    logic [7:0]                held [2]    = '{8'h00, 8'h00};
    logic [7:0]                body_left   = 8'h00;
    logic                      capturing   = 1'b0;
    logic [7:0]                cap_target  = 8'h00;
    logic [hfi_pkg::CNT_W-1:0] cap_count   = '0;

    logic [7:0] outbound [$];
    beat_t      sorted_beats_due [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic stall_req     = 1'b0;
    logic stall_ack;
    int   stall_left;
    int   mismatches    = 0;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void sort_host_byte(input logic [7:0] b);
        beat_t list [$];
        logic  done;
        if (capturing)
        begin
            cap_count = cap_count + hfi_pkg::CNT_W'(1);
            done = ({4'd0, cap_count} >= cap_target);
            if (done)
                capturing = 1'b0;
            list.push_back(beat_t'{hfi_pkg::ROUTE_BRIDGE, b, done, 1'b0});
        end
        else if (body_left != 8'd0)
        begin
            body_left = body_left - 8'd1;
            list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, b, 1'b0, 1'b0});
        end
        else if (held_cnt == hfi_pkg::HELD_IMU)
        begin
            held_cnt = hfi_pkg::HELD_NONE;
            if (b == cfg.imu_check)
                list.push_back(beat_t'{hfi_pkg::ROUTE_IMU, 8'h00, 1'b0, 1'b0});
            else
            begin
                list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, held[0], 1'b0, 1'b0});
                list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, held[1], 1'b0, 1'b0});
                list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, b, 1'b0, 1'b0});
            end
        end
        else if (held_cnt == hfi_pkg::HELD_NONE)
        begin
            // lengths 0 and 1 go straight through
            if (b < hfi_pkg::HDR_LEN)
                list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, b, 1'b0, 1'b0});
            else
            begin
                held[0]  = b;
                held_cnt = hfi_pkg::HELD_ONE;
            end
        end
        else
        begin
            held[1] = b;
            if (held[0] == hfi_pkg::IMU_LEN_BYTE && b == cfg.imu_cmd)
                held_cnt = hfi_pkg::HELD_IMU;
            else
            begin
                held_cnt = hfi_pkg::HELD_NONE;
                if (b == cfg.bridge_opcode && held[0] <= CAPTURE_DEPTH)
                begin
                    // a bridge frame of header only is dropped
                    if (held[0] > hfi_pkg::HDR_LEN)
                    begin
                        cap_target = held[0];
                        cap_count  = hfi_pkg::CNT_W'(2);
                        capturing  = 1'b1;
                        list.push_back(beat_t'{hfi_pkg::ROUTE_BRIDGE, held[0], 1'b0, 1'b0});
                        list.push_back(beat_t'{hfi_pkg::ROUTE_BRIDGE, b, 1'b0, 1'b0});
                    end
                end
                else
                begin
                    body_left = held[0] - hfi_pkg::HDR_LEN;
                    list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, held[0], 1'b0, 1'b0});
                    list.push_back(beat_t'{hfi_pkg::ROUTE_BOARD, b, 1'b0, 1'b0});
                end
            end
        end
        if (list.size() != 0)
            list[list.size() - 1].last = 1'b1;
        foreach (list[i])
            sorted_beats_due.push_back(list[i]);
    endfunction

    function automatic int queue_bridge(input int len);
        outbound.push_back(8'(len));
        outbound.push_back(cfg.bridge_opcode);
        for (int i = 2; i < len; i++)
            outbound.push_back(8'($urandom_range(255)));
        return len;
    endfunction

    function automatic int queue_frame();
        int pick;
        int len;
        int k;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            outbound.push_back(8'(len));
            outbound.push_back(8'($urandom_range(255)));
            for (int i = 2; i < len; i++)
                outbound.push_back(8'($urandom_range(255)));
            return len;
        end
        else if (pick < 60)
        begin
            outbound.push_back(hfi_pkg::IMU_LEN_BYTE);
            outbound.push_back(cfg.imu_cmd);
            if ($urandom_range(3) == 0)
                outbound.push_back(8'($urandom_range(255)));
            else
                outbound.push_back(cfg.imu_check);
            return 3;
        end
        else if (pick < 85)
            return queue_bridge($urandom_range(hfi_pkg::HDR_LEN, CAPTURE_DEPTH + 2));
        else if (pick < 90)
        begin
            outbound.push_back(8'($urandom_range(1)));
            return 1;
        end
        // stray bytes that break frame alignment
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
            outbound.push_back(8'($urandom_range(15)));
        return k;
    endfunction

    task automatic run_random(input int count);
        int queued;
        queued = 0;
        @(negedge clk);
        while (queued < count)
            queued += queue_frame();
    endtask

    task automatic drain();
        @(negedge clk);
        while (outbound.size() != 0 || host_ch.valid || sorted_beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [hfi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            hfi_pkg::REG_IMU_CMD:       cfg.imu_cmd       = val;
            hfi_pkg::REG_IMU_CHECK:     cfg.imu_check     = val;
            hfi_pkg::REG_BRIDGE_OPCODE: cfg.bridge_opcode = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] opc, input logic [7:0] chk,
                             input logic [7:0] bridge);
        cfg_write(hfi_pkg::REG_IMU_CMD, opc);
        cfg_write(hfi_pkg::REG_IMU_CHECK, chk);
        cfg_write(hfi_pkg::REG_BRIDGE_OPCODE, bridge);
        @(negedge clk);
    endtask

    // host side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_ch.valid     <= 1'b0;
            host_ch.host_byte <= 8'h00;
        end
        else
        begin
            if (host_ch.valid && host_ch.ready)
                sort_host_byte(host_ch.host_byte);
            if (!host_ch.valid || host_ch.ready)
            begin
                if (outbound.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    host_ch.valid     <= 1'b1;
                    host_ch.host_byte <= outbound.pop_front();
                end
                else
                    host_ch.valid <= 1'b0;
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_ack       <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_ack != stall_req)
        begin
            stall_ack       <= stall_req;
            stall_left      <= LONG_STALL;
            result_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result beat checker
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (sorted_beats_due.size() == 0)
            begin
                $error("unexpected beat: route %0d data_byte %02h", result_ch.route,
                       result_ch.data_byte);
                mismatches++;
            end
            else
            begin
                want = sorted_beats_due.pop_front();
                if (result_ch.route !== want.route)
                begin
                    $error("route: expected %0d, got %0d", want.route, result_ch.route);
                    mismatches++;
                end
                if (result_ch.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %02h, got %02h", want.data_byte,
                           result_ch.data_byte);
                    mismatches++;
                end
                if (result_ch.bridge_done !== want.bridge_done)
                begin
                    $error("bridge_done: expected %0d, got %0d", want.bridge_done,
                           result_ch.bridge_done);
                    mismatches++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((host_ch.valid && host_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = hfi_pkg::REG_IMU_CMD;
        wr_data           = 8'h00;
        cfg.imu_cmd       = hfi_pkg::IMU_CMD_RESET;
        cfg.imu_check     = hfi_pkg::IMU_CHECK_RESET;
        cfg.bridge_opcode = hfi_pkg::BRIDGE_OPC_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        send_idle_pct = 7;
        recv_idle_pct = 79;
        // short lengths, plain frame, imu hit and miss, dropped bridge,
        // bridge captures, then an imu header left waiting for its check byte
        outbound = '{8'h00, 8'h01,
                     8'h05, 8'h22, 8'hFF, 8'h00, 8'h7E,
                     hfi_pkg::IMU_LEN_BYTE, hfi_pkg::IMU_CMD_RESET, hfi_pkg::IMU_CHECK_RESET,
                     hfi_pkg::IMU_LEN_BYTE, hfi_pkg::IMU_CMD_RESET, 8'h55,
                     8'h02, hfi_pkg::BRIDGE_OPC_RESET,
                     8'h04, hfi_pkg::BRIDGE_OPC_RESET, 8'hAB, 8'hCD,
                     hfi_pkg::IMU_LEN_BYTE, hfi_pkg::BRIDGE_OPC_RESET, 8'h77,
                     hfi_pkg::IMU_LEN_BYTE, hfi_pkg::IMU_CMD_RESET};
        drain();

        // imu and bridge opcodes equal; held header checked against new value
        write_all(8'hFF, 8'h00, 8'hFF);
        outbound.push_back(8'h00);
        run_random(16);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 7;
        write_all(8'h00, 8'hFF, 8'h80);
        @(negedge clk);
        void'(queue_bridge(CAPTURE_DEPTH));
        void'(queue_bridge(CAPTURE_DEPTH + 1));
        run_random(10);
        drain();
        run_random(10);
        drain();

        write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random(16);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(hfi_pkg::IMU_CMD_RESET, hfi_pkg::IMU_CHECK_RESET, hfi_pkg::BRIDGE_OPC_RESET);
        run_random(16);
        stall_req = ~stall_req;
        drain();

        cfg_write(hfi_pkg::REG_IMU_CHECK, 8'($urandom_range(255)));
        cfg_write(hfi_pkg::REG_BRIDGE_OPCODE, 8'($urandom_range(255)));
        run_random(16);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
